// ----- hw/rtl/median_outlier_sensor_voter_assert.svh -----
// ----------------------------------------------------------------------------
// median outlier sensor voter assertion macros
// shared concurrent assertion forms, held off while reset is high
// ----------------------------------------------------------------------------
`ifndef MEDIAN_OUTLIER_SENSOR_VOTER_ASSERT_SVH
`define MEDIAN_OUTLIER_SENSOR_VOTER_ASSERT_SVH

// same-cycle implication
`define MOSV_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("mosv assertion failed");

// next-cycle implication
`define MOSV_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("mosv assertion failed");

`endif

// ----- hw/rtl/mosv_pkg.sv -----
// ----------------------------------------------------------------------------
// mosv_pkg
// shared types and constants of the median outlier sensor voter
// ----------------------------------------------------------------------------
`default_nettype none

package mosv_pkg;

  localparam int THRESH_W     = 16;
  localparam int LIMIT_W      = 3;
  localparam int CNT_W        = 3;
  localparam int COUNT_MAX    = 7;
  localparam int CFG_IDX_W    = 4;
  localparam int THRESH_RESET = 256;
  localparam int LIMIT_RESET  = 2;
  // quotient bits resolved per divider stage
  localparam int DIV_BITS     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTLIER_THRESHOLD     = CFG_IDX_W'(0),
    REG_ALLOWED_OUTLIER_LIMIT = CFG_IDX_W'(1)
  } mosv_reg_t;

  typedef struct packed {
    logic             failure;
    logic [CNT_W-1:0] outlier_count;
  } mosv_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mosv_rank_lane.sv -----
// ----------------------------------------------------------------------------
// mosv_rank_lane
// sort rank of one reading among all readings of an item, ties by position
// ----------------------------------------------------------------------------
`default_nettype none

module mosv_rank_lane #(
  parameter int N   = 5,
  parameter int RW  = 16,
  parameter int IDX = 0
) (
  input  logic [N-1:0][RW-1:0]    vals,
  output logic [$clog2(N)-1:0]    rank
);

  import mosv_pkg::*;

  always_comb begin
    rank = '0;
    for (int j = 0; j < N; j++) begin
      if (j != IDX) begin
        if ((vals[j] < vals[IDX]) || ((vals[j] == vals[IDX]) && (j < IDX))) begin
          rank = rank + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mosv_dev_lane.sv -----
// ----------------------------------------------------------------------------
// mosv_dev_lane
// absolute deviation of one reading from the median, checked against threshold
// ----------------------------------------------------------------------------
`default_nettype none

module mosv_dev_lane #(
  parameter int RW = 16
) (
  input  logic [RW-1:0]                 value,
  input  logic [RW-1:0]                 median,
  input  logic [mosv_pkg::THRESH_W-1:0] threshold,
  output logic                          accept
);

  import mosv_pkg::*;

  localparam int CW = (RW > THRESH_W) ? RW : THRESH_W;

  logic [RW-1:0] dev;

  assign dev    = (value >= median) ? (value - median) : (median - value);
  // equal to threshold still passes
  assign accept = CW'(dev) <= CW'(threshold);

endmodule

`default_nettype wire

// ----- hw/rtl/mosv_div_pipe.sv -----
// ----------------------------------------------------------------------------
// mosv_div_pipe
// pipelined restoring divider for a small divisor, status rides along
// ----------------------------------------------------------------------------
`default_nettype none

`include "median_outlier_sensor_voter_assert.svh"

module mosv_div_pipe #(
  parameter int DIVIDEND_W = 19,
  parameter int DIVISOR_W  = 3,
  parameter int QUOT_W     = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [DIVIDEND_W-1:0]  in_dividend,
  input  logic [DIVISOR_W-1:0]   in_divisor,
  input  mosv_pkg::mosv_status_t in_status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [QUOT_W-1:0]      quotient,
  output mosv_pkg::mosv_status_t out_status
);

  import mosv_pkg::*;

  localparam int STAGES = (DIVIDEND_W + DIV_BITS - 1) / DIV_BITS;
  localparam int PAD_W  = STAGES * DIV_BITS;

  logic [STAGES-1:0]    vld;
  logic [STAGES:0]      rdy;
  logic [PAD_W-1:0]     num [STAGES];
  logic [PAD_W-1:0]     quo [STAGES];
  logic [DIVISOR_W-1:0] rem [STAGES];
  logic [DIVISOR_W-1:0] dv  [STAGES];
  mosv_status_t         st  [STAGES];

  assign rdy[STAGES] = out_ready;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic                 src_vld;
    logic [PAD_W-1:0]     src_num, src_quo, nxt_num, nxt_quo;
    logic [DIVISOR_W-1:0] src_rem, src_dv, nxt_rem;
    mosv_status_t         src_st;
    logic [DIVISOR_W:0]   part;
    logic                 qbit;

    if (s == 0) begin : g_head
      assign src_vld = in_valid;
      assign src_num = PAD_W'(in_dividend);
      assign src_quo = '0;
      assign src_rem = '0;
      assign src_dv  = in_divisor;
      assign src_st  = in_status;
    end else begin : g_body
      assign src_vld = vld[s-1];
      assign src_num = num[s-1];
      assign src_quo = quo[s-1];
      assign src_rem = rem[s-1];
      assign src_dv  = dv[s-1];
      assign src_st  = st[s-1];
    end

    // one quotient bit per step, msb first
    always_comb begin
      nxt_num = src_num;
      nxt_quo = src_quo;
      nxt_rem = src_rem;
      part    = '0;
      qbit    = 1'b0;
      for (int k = 0; k < DIV_BITS; k++) begin
        part    = {nxt_rem, nxt_num[PAD_W-1]};
        nxt_num = {nxt_num[PAD_W-2:0], 1'b0};
        qbit    = part >= {1'b0, src_dv};
        if (qbit) begin
          part = part - {1'b0, src_dv};
        end
        nxt_quo = {nxt_quo[PAD_W-2:0], qbit};
        nxt_rem = part[DIVISOR_W-1:0];
      end
    end

    assign rdy[s] = !vld[s] || rdy[s+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        num[s] <= nxt_num;
        quo[s] <= nxt_quo;
        rem[s] <= nxt_rem;
        dv[s]  <= src_dv;
        st[s]  <= src_st;
      end
    end
  end

  assign in_ready   = rdy[0];
  assign out_valid  = vld[STAGES-1];
  assign quotient   = quo[STAGES-1][QUOT_W-1:0];
  assign out_status = st[STAGES-1];

  `MOSV_ASSERT_IMPL(a_divisor_nonzero, clk, rst, vld[0], dv[0] != '0)
  `MOSV_ASSERT_IMPL(a_rem_below_divisor, clk, rst, vld[STAGES-1], rem[STAGES-1] < dv[STAGES-1])
  `MOSV_ASSERT_NEXT(a_head_holds, clk, rst, vld[0] && !rdy[0], vld[0] && $stable(quo[0]))

endmodule

`default_nettype wire

// ----- hw/rtl/median_outlier_sensor_voter.sv -----
// ----------------------------------------------------------------------------
// median_outlier_sensor_voter
// median vote over redundant distance readings with outlier rejection
// ----------------------------------------------------------------------------
// usage
//   s_* : one item holds SENSOR_COUNT readings, unsigned 8.8, reading 0 lowest
//   m_* : one item per input item: fused distance, outlier count, failure flag
//   cfg : write port, index 0 outlier threshold, index 1 allowed outlier limit;
//         always ready, write only while no item is in flight
// throughput: one item per cycle while m_tready stays high
// structure: input capture, rank lanes, median pick, deviation lanes, pair sums
//   and total sum register stages, then the divider pipeline that forms the
//   mean, 4 quotient bits a stage, whose last stage is the output register
// stall: each stage moves on when its successor is empty or moving, so a
//   stalled receiver fills the empty stages first; s_tready drops only once
//   every stage holds an item, and nothing is lost or repeated
// reset: threshold back to 1.0 ft (256), limit back to 2, pipeline emptied
// ----------------------------------------------------------------------------
`default_nettype none

`include "median_outlier_sensor_voter_assert.svh"

module median_outlier_sensor_voter #(
  parameter int SENSOR_COUNT  = 5,
  parameter int READING_WIDTH = 16,
  localparam int IN_W  = ((SENSOR_COUNT * READING_WIDTH) + 7) / 8 * 8,
  localparam int OUT_W = ((READING_WIDTH + 4) + 7) / 8 * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // reading_0, reading_1, ... each READING_WIDTH bits, zero pad on top
  input  logic [IN_W-1:0]                  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // fused_distance, outlier_count (3), failure (1), zero pad on top
  output logic [OUT_W-1:0]                 m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mosv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mosv_pkg::THRESH_W-1:0]    cfg_data
);

  import mosv_pkg::*;

  localparam int N      = SENSOR_COUNT;
  localparam int RW     = READING_WIDTH;
  localparam int RANK_W = $clog2(N);
  localparam int ACC_W  = $clog2(N + 1);
  localparam int SUM_W  = RW + $clog2(N);
  localparam int NP     = (N + 1) / 2;
  localparam int MID    = N / 2;
  localparam bit EVEN   = (N % 2) == 0;
  localparam int CMPW   = (ACC_W > CNT_W) ? ACC_W : CNT_W;

  // configuration registers
  logic [THRESH_W-1:0] outlier_threshold;
  logic [LIMIT_W-1:0]  allowed_outlier_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      outlier_threshold     <= THRESH_W'(THRESH_RESET);
      allowed_outlier_limit <= LIMIT_W'(LIMIT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OUTLIER_THRESHOLD:     outlier_threshold     <= cfg_data;
        REG_ALLOWED_OUTLIER_LIMIT: allowed_outlier_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline occupancy, stage k moves when it is empty or k+1 moves
  logic [5:0] vld;
  logic [6:0] rdy;
  logic       div_in_ready;

  assign rdy[6] = div_in_ready;
  for (genvar k = 0; k < 6; k++) begin : g_flow
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  assign s_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < 6; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 0: input capture
  logic [N-1:0][RW-1:0] val0;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int i = 0; i < N; i++) begin
        val0[i] <= s_tdata[i*RW +: RW];
      end
    end
  end

  // stage 1: rank lanes
  logic [N-1:0][RW-1:0]     val1;
  logic [RANK_W-1:0]        rank_w [N];
  logic [RANK_W-1:0]        rank1  [N];

  for (genvar i = 0; i < N; i++) begin : g_rank
    mosv_rank_lane #(
      .N   (N),
      .RW  (RW),
      .IDX (i)
    ) u_rank (
      .vals (val0),
      .rank (rank_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      val1 <= val0;
      for (int i = 0; i < N; i++) begin
        rank1[i] <= rank_w[i];
      end
    end
  end

  // stage 2: merge, pick the middle rank(s)
  logic [N-1:0]         sel_hi, sel_lo;
  logic [RW-1:0]        hi_val, lo_val, med_w;
  logic [RW:0]          mid_sum;
  logic [N-1:0][RW-1:0] val2;
  logic [RW-1:0]        med2;

  always_comb begin
    hi_val = '0;
    lo_val = '0;
    for (int i = 0; i < N; i++) begin
      sel_hi[i] = rank1[i] == RANK_W'(MID);
      sel_lo[i] = rank1[i] == RANK_W'(MID - 1);
      hi_val    = hi_val | (sel_hi[i] ? val1[i] : '0);
      lo_val    = lo_val | (sel_lo[i] ? val1[i] : '0);
    end
  end

  // even count: truncated mean of the two middle readings
  assign mid_sum = {1'b0, hi_val} + {1'b0, lo_val};
  assign med_w   = EVEN ? mid_sum[RW:1] : hi_val;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      val2 <= val1;
      med2 <= med_w;
    end
  end

  // stage 3: deviation lanes
  logic [N-1:0]         acc_w;
  logic [N-1:0]         acc3;
  logic [N-1:0][RW-1:0] val3;

  for (genvar i = 0; i < N; i++) begin : g_dev
    mosv_dev_lane #(
      .RW (RW)
    ) u_dev (
      .value     (val2[i]),
      .median    (med2),
      .threshold (outlier_threshold),
      .accept    (acc_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      val3 <= val2;
      acc3 <= acc_w;
    end
  end

  // stage 4: pair sums of accepted readings, counts and failure
  logic [RW:0]        psum_w [NP];
  logic [RW:0]        psum4  [NP];
  logic [ACC_W-1:0]   acc_cnt_w, acc_cnt4, raw_out;
  mosv_status_t       stat_w, stat4;

  for (genvar p = 0; p < NP; p++) begin : g_pair
    if (2 * p + 1 < N) begin : g_two
      assign psum_w[p] = {1'b0, (acc3[2*p] ? val3[2*p] : '0)}
                       + {1'b0, (acc3[2*p+1] ? val3[2*p+1] : '0)};
    end else begin : g_one
      assign psum_w[p] = {1'b0, (acc3[2*p] ? val3[2*p] : '0)};
    end
  end

  always_comb begin
    acc_cnt_w = '0;
    for (int i = 0; i < N; i++) begin
      acc_cnt_w = acc_cnt_w + ACC_W'(acc3[i]);
    end
  end

  assign raw_out = ACC_W'(N) - acc_cnt_w;

  // count saturates at seven when more than seven readings are rejected
  assign stat_w.outlier_count = (CMPW'(raw_out) > CMPW'(COUNT_MAX)) ?
                                CNT_W'(COUNT_MAX) : CNT_W'(raw_out);
  assign stat_w.failure = (CMPW'(raw_out) > CMPW'(allowed_outlier_limit)) ||
                          (acc_cnt_w == '0);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int p = 0; p < NP; p++) begin
        psum4[p] <= psum_w[p];
      end
      acc_cnt4 <= acc_cnt_w;
      stat4    <= stat_w;
    end
  end

  // stage 5: total sum, divisor forced to one when nothing survived
  logic [SUM_W-1:0] sum_w, sum5;
  logic [ACC_W-1:0] dv5;
  mosv_status_t     stat5;

  always_comb begin
    sum_w = '0;
    for (int p = 0; p < NP; p++) begin
      sum_w = sum_w + SUM_W'(psum4[p]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      sum5  <= sum_w;
      dv5   <= (acc_cnt4 == '0) ? ACC_W'(1) : acc_cnt4;
      stat5 <= stat4;
    end
  end

  // mean of accepted readings, also the output register
  logic [RW-1:0] fused_distance;
  mosv_status_t  out_stat;

  mosv_div_pipe #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (ACC_W),
    .QUOT_W     (RW)
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (vld[5]),
    .in_ready    (div_in_ready),
    .in_dividend (sum5),
    .in_divisor  (dv5),
    .in_status   (stat5),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .quotient    (fused_distance),
    .out_status  (out_stat)
  );

  assign m_tdata = OUT_W'({out_stat.failure, out_stat.outlier_count, fused_distance});

  `MOSV_ASSERT_IMPL(a_median_onehot, clk, rst, vld[1], $onehot(sel_hi))
  `MOSV_ASSERT_IMPL(a_none_accepted_fails, clk, rst, vld[4] && (acc_cnt4 == '0), stat4.failure)
  `MOSV_ASSERT_NEXT(a_sum_held, clk, rst, vld[5] && !div_in_ready, vld[5] && $stable(sum5))

endmodule

`default_nettype wire
